// ----- sv/dcdc_pkg.sv -----
package dcdc_pkg;

  localparam int unsigned CMD_W   = 1;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned YLEN_W  = 9;

  localparam logic [CMD_W-1:0]   CMD_DECODE = 1'b0;
  localparam logic [CMD_W-1:0]   CMD_ENCODE = 1'b1;

  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [DAY_W-1:0]   FEB_BASE    = 5'd28;
  localparam logic [WDAY_W-1:0]  WEEK_LAST   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_WDAY,
    ST_DONE
  } state_e;

  // Length of a month in days; codes outside 1..12 never reach a valid result.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Adds a small step to a weekday and wraps it back into 0..6.
  function automatic logic [WDAY_W-1:0] wday_add(input logic [WDAY_W-1:0] w,
                                                  input logic [1:0] step);
    logic [WDAY_W:0] sum;
    sum = {1'b0, w} + {2'b00, step};
    if (sum > {1'b0, WEEK_LAST}) begin
      sum = sum - 4'd7;
    end
    return sum[WDAY_W-1:0];
  endfunction

endpackage

// ----- sv/day_count_date_converter.sv -----
// Gregorian date converter. A transfer with command_i low decodes day_count_i, the number
// of days since 1 January FIRST_YEAR, into year, month, day of month and weekday
// (0 is Sunday); with command_i high it checks year_in_i, month_in_i and day_in_i and
// returns the matching day count. Results outside the years FIRST_YEAR through
// FIRST_YEAR + YEAR_SPAN - 1, and bad months or days, come back with valid_res_o low.
// One request is handled at a time: a shared 17-bit adder walks one year per cycle and
// then one month per cycle, then adds the day offset, and repeated subtraction of seven
// reduces the weekday modulo seven. in_ready_o stays low from the input transfer until
// the result has been taken.
module day_count_date_converter #(
  parameter int unsigned FIRST_YEAR = 1970,
  parameter int unsigned YEAR_SPAN  = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [dcdc_pkg::CMD_W-1:0]      command_i,
  input  logic [dcdc_pkg::COUNT_W-1:0]    day_count_i,
  input  logic [dcdc_pkg::YEAR_W-1:0]     year_in_i,
  input  logic [dcdc_pkg::MONTH_W-1:0]    month_in_i,
  input  logic [dcdc_pkg::DAY_W-1:0]      day_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dcdc_pkg::YEAR_W-1:0]     year_out_o,
  output logic [dcdc_pkg::MONTH_W-1:0]    month_out_o,
  output logic [dcdc_pkg::DAY_W-1:0]      day_out_o,
  output logic [dcdc_pkg::WDAY_W-1:0]     weekday_o,
  output logic [dcdc_pkg::COUNT_W-1:0]    count_out_o,
  output logic                            valid_res_o
);

  localparam int unsigned SPAN_W = $clog2(YEAR_SPAN + 1);
  localparam int unsigned PRIOR  = FIRST_YEAR - 1;
  localparam int unsigned FIRST_WD_INT =
    (1 + 365 * PRIOR + PRIOR / 4 - PRIOR / 100 + PRIOR / 400) % 7;

  localparam logic [dcdc_pkg::YEAR_W-1:0] YEAR_FIRST = dcdc_pkg::YEAR_W'(FIRST_YEAR);
  localparam logic [dcdc_pkg::YEAR_W:0]   YEAR_END   = (dcdc_pkg::YEAR_W + 1)'(FIRST_YEAR + YEAR_SPAN);
  localparam logic [SPAN_W-1:0]           SPAN_LAST  = SPAN_W'(YEAR_SPAN);
  localparam logic [6:0]                  C100_INIT  = 7'(FIRST_YEAR % 100);
  localparam logic [1:0]                  C4H_INIT   = 2'((FIRST_YEAR / 100) % 4);
  localparam logic [dcdc_pkg::WDAY_W-1:0] FIRST_WD   = dcdc_pkg::WDAY_W'(FIRST_WD_INT);

  dcdc_pkg::state_e state_q, state_d;

  logic [dcdc_pkg::CMD_W-1:0]   cmd_q;
  logic [dcdc_pkg::COUNT_W-1:0] cnt_q;
  logic [dcdc_pkg::YEAR_W-1:0]  yin_q;
  logic [dcdc_pkg::MONTH_W-1:0] min_q;
  logic [dcdc_pkg::DAY_W-1:0]   din_q;

  logic [dcdc_pkg::COUNT_W-1:0] acc_q, acc_d;
  logic [dcdc_pkg::YEAR_W-1:0]  year_q, year_d;
  logic [SPAN_W-1:0]            span_q, span_d;
  logic [6:0]                   c100_q, c100_d;
  logic [1:0]                   c4h_q, c4h_d;
  logic [dcdc_pkg::MONTH_W-1:0] month_q, month_d;
  logic [dcdc_pkg::WDAY_W-1:0]  wd_q, wd_d;
  logic [dcdc_pkg::DAY_W-1:0]   day_q, day_d;
  logic [5:0]                   wsum_q, wsum_d;

  logic [dcdc_pkg::YEAR_W-1:0]  year_out_q, year_out_d;
  logic [dcdc_pkg::MONTH_W-1:0] month_out_q, month_out_d;
  logic [dcdc_pkg::DAY_W-1:0]   day_out_q, day_out_d;
  logic [dcdc_pkg::WDAY_W-1:0]  weekday_q, weekday_d;
  logic [dcdc_pkg::COUNT_W-1:0] count_out_q, count_out_d;
  logic                         valid_res_q, valid_res_d;

  logic                         in_xfer;
  logic                         decode;
  logic                         leap;
  logic [dcdc_pkg::YLEN_W-1:0]  ylen;
  logic [dcdc_pkg::DAY_W-1:0]   mlen;
  logic [dcdc_pkg::DAY_W-1:0]   dayoff;
  logic                         enc_ok;
  logic                         day_ok;
  logic                         sub;
  logic [dcdc_pkg::COUNT_W-1:0] op;
  logic [dcdc_pkg::COUNT_W-1:0] op_x;
  logic [dcdc_pkg::COUNT_W:0]   res;
  logic                         no_borrow;
  logic                         year_bad;
  logic                         year_stop;
  logic                         year_step;
  logic                         month_step;
  logic                         wday_done;

  assign in_xfer = in_valid_i && in_ready_o;
  assign decode  = (cmd_q == dcdc_pkg::CMD_DECODE);

  // Leap year: divisible by 4 and not by 100, or divisible by 400.
  assign leap = (year_q[1:0] == 2'd0) && ((c100_q != 7'd0) || (c4h_q == 2'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = dcdc_pkg::month_len(month_q, leap);
  assign dayoff = decode ? acc_q[dcdc_pkg::DAY_W-1:0] : din_q - 5'd1;

  assign enc_ok = (yin_q >= YEAR_FIRST) && ({1'b0, yin_q} < YEAR_END) &&
                  (min_q >= dcdc_pkg::MONTH_FIRST) && (min_q <= dcdc_pkg::MONTH_LAST);
  assign day_ok = (din_q != 5'd0) && (din_q <= dcdc_pkg::month_len(min_q, leap));

  // The shared adder: subtracts year and month lengths while decoding, adds while encoding.
  always_comb begin
    case (state_q)
      dcdc_pkg::ST_YEAR:  op = dcdc_pkg::COUNT_W'(ylen);
      dcdc_pkg::ST_MONTH: op = dcdc_pkg::COUNT_W'(mlen);
      dcdc_pkg::ST_DAY:   op = dcdc_pkg::COUNT_W'(dayoff);
      default:            op = '0;
    endcase
    sub  = decode && (state_q != dcdc_pkg::ST_DAY);
    op_x = sub ? ~op : op;
    res  = {1'b0, acc_q} + {1'b0, op_x} + {{dcdc_pkg::COUNT_W{1'b0}}, sub};
    no_borrow = res[dcdc_pkg::COUNT_W];
  end

  always_comb begin
    if (decode) begin
      year_bad   = (span_q == SPAN_LAST);
      year_stop  = !no_borrow;
      month_step = (month_q < dcdc_pkg::MONTH_LAST) && no_borrow;
    end else begin
      year_bad   = !enc_ok || ((year_q == yin_q) && !day_ok);
      year_stop  = (year_q == yin_q);
      month_step = (month_q < min_q);
    end
    year_step = !year_bad && !year_stop;
    wday_done = (wsum_q < 6'd7);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dcdc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = dcdc_pkg::ST_YEAR;
        end
      end
      dcdc_pkg::ST_YEAR: begin
        if (year_bad) begin
          state_d = dcdc_pkg::ST_DONE;
        end else if (year_stop) begin
          state_d = dcdc_pkg::ST_MONTH;
        end
      end
      dcdc_pkg::ST_MONTH: begin
        if (!month_step) begin
          state_d = dcdc_pkg::ST_DAY;
        end
      end
      dcdc_pkg::ST_DAY: begin
        state_d = dcdc_pkg::ST_WDAY;
      end
      dcdc_pkg::ST_WDAY: begin
        if (wday_done) begin
          state_d = dcdc_pkg::ST_DONE;
        end
      end
      dcdc_pkg::ST_DONE: begin
        if (out_ready_i) begin
          state_d = dcdc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dcdc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == dcdc_pkg::ST_IDLE);
    out_valid_o = (state_q == dcdc_pkg::ST_DONE);
  end

  always_comb begin
    acc_d       = acc_q;
    year_d      = year_q;
    span_d      = span_q;
    c100_d      = c100_q;
    c4h_d       = c4h_q;
    month_d     = month_q;
    wd_d        = wd_q;
    day_d       = day_q;
    wsum_d      = wsum_q;
    year_out_d  = year_out_q;
    month_out_d = month_out_q;
    day_out_d   = day_out_q;
    weekday_d   = weekday_q;
    count_out_d = count_out_q;
    valid_res_d = valid_res_q;
    case (state_q)
      dcdc_pkg::ST_IDLE: begin
        acc_d   = (command_i == dcdc_pkg::CMD_DECODE) ? day_count_i : '0;
        year_d  = YEAR_FIRST;
        span_d  = '0;
        c100_d  = C100_INIT;
        c4h_d   = C4H_INIT;
        month_d = dcdc_pkg::MONTH_FIRST;
        wd_d    = FIRST_WD;
      end
      dcdc_pkg::ST_YEAR: begin
        if (year_bad) begin
          year_out_d  = decode ? '0 : yin_q;
          month_out_d = '0;
          day_out_d   = '0;
          weekday_d   = '0;
          count_out_d = decode ? cnt_q : '0;
          valid_res_d = 1'b0;
        end else if (year_step) begin
          acc_d  = res[dcdc_pkg::COUNT_W-1:0];
          year_d = year_q + 12'd1;
          span_d = span_q + SPAN_W'(1);
          wd_d   = dcdc_pkg::wday_add(wd_q, leap ? 2'd2 : 2'd1);
          if (c100_q == 7'd99) begin
            c100_d = '0;
            c4h_d  = c4h_q + 2'd1;
          end else begin
            c100_d = c100_q + 7'd1;
          end
        end
      end
      dcdc_pkg::ST_MONTH: begin
        if (month_step) begin
          acc_d   = res[dcdc_pkg::COUNT_W-1:0];
          month_d = month_q + 4'd1;
          wd_d    = dcdc_pkg::wday_add(wd_q, 2'(mlen - dcdc_pkg::FEB_BASE));
        end
      end
      dcdc_pkg::ST_DAY: begin
        if (!decode) begin
          acc_d = res[dcdc_pkg::COUNT_W-1:0];
        end
        day_d  = dayoff + 5'd1;
        wsum_d = {3'b000, wd_q} + {1'b0, dayoff};
      end
      dcdc_pkg::ST_WDAY: begin
        if (wday_done) begin
          year_out_d  = year_q;
          month_out_d = month_q;
          day_out_d   = day_q;
          weekday_d   = wsum_q[dcdc_pkg::WDAY_W-1:0];
          count_out_d = decode ? cnt_q : acc_q;
          valid_res_d = 1'b1;
        end else begin
          wsum_d = wsum_q - 6'd7;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcdc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= command_i;
      cnt_q <= day_count_i;
      yin_q <= year_in_i;
      min_q <= month_in_i;
      din_q <= day_in_i;
    end
    acc_q       <= acc_d;
    year_q      <= year_d;
    span_q      <= span_d;
    c100_q      <= c100_d;
    c4h_q       <= c4h_d;
    month_q     <= month_d;
    wd_q        <= wd_d;
    day_q       <= day_d;
    wsum_q      <= wsum_d;
    year_out_q  <= year_out_d;
    month_out_q <= month_out_d;
    day_out_q   <= day_out_d;
    weekday_q   <= weekday_d;
    count_out_q <= count_out_d;
    valid_res_q <= valid_res_d;
  end

  assign year_out_o  = year_out_q;
  assign month_out_o = month_out_q;
  assign day_out_o   = day_out_q;
  assign weekday_o   = weekday_q;
  assign count_out_o = count_out_q;
  assign valid_res_o = valid_res_q;

endmodule

// ----- sv/dcdc_checker.sv -----
module dcdc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [dcdc_pkg::MONTH_W-1:0]    month_out_o,
  input logic [dcdc_pkg::DAY_W-1:0]      day_out_o,
  input logic [dcdc_pkg::WDAY_W-1:0]     weekday_o,
  input logic                            valid_res_o
);

  // Only one request is in flight, so both sides never offer a transfer together.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready stayed high after an input transfer");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> (in_ready_o && !out_valid_o))
    else $error("block did not return to idle after a result transfer");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (month_out_o == '0 && day_out_o == '0 && weekday_o == '0))
    else $error("rejected request carries a nonzero date");

  a_valid_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      (month_out_o >= dcdc_pkg::MONTH_FIRST && month_out_o <= dcdc_pkg::MONTH_LAST &&
       day_out_o != '0 && weekday_o <= dcdc_pkg::WEEK_LAST))
    else $error("accepted result carries an impossible date");

endmodule

bind day_count_date_converter dcdc_checker u_dcdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .month_out_o (month_out_o),
  .day_out_o   (day_out_o),
  .weekday_o   (weekday_o),
  .valid_res_o (valid_res_o)
);
